>>> design/kwe_pkg.sv
// Package for the k-mer window extractor.
// Holds shared constants, byte codes and the sequencer state type; no dependencies.
`default_nettype none

package kwe_pkg;

   // Default window storage depth and the k value after reset
   localparam int          MAX_KMER_DEF   = 32;
   localparam logic [5:0]  KMER_LEN_RESET = 6'd18;

   // Byte codes with special meaning in the stream
   localparam logic [7:0]  BYTE_N  = 8'h4E;
   localparam logic [7:0]  BYTE_NL = 8'h0A;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND
   } kwe_state_type;

endpackage

`default_nettype wire

>>> design/kmer_window_extractor_top.sv
// K-mer window extractor: window memory, intake logic and serial emit sequencer.
// Depends on kwe_pkg for constants and the state type.
`default_nettype none

// Takes a FASTA-style stream one byte per transaction. Bytes up to the first
// newline are the header and are dropped; newlines are always dropped. Other
// bytes go into a circular window memory. When the window holds k bytes with no
// uppercase 'N', the k bytes go out oldest first, kmer_last on the final one.
// A byte that emits nothing leaves the sequencer idle, and the next byte can
// follow in the next cycle. A byte that completes a clean window is accepted
// and written, then the oldest byte is read from the window memory, then the
// bytes go out one by one, held by any output stall, all through the
// single memory read port. req_stall is high while a k-mer is going out, and
// csr_ready is low then. A write to kmer_length empties the window; values
// above MAX_KMER act as MAX_KMER and zero never emits.
module kmer_window_extractor_top #(
   parameter int MAX_KMER = kwe_pkg::MAX_KMER_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // byte input
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_stream_byte,
   // k-mer output
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_kmer_char,
   output logic            rsp_kmer_last,
   // configuration
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [5:0] csr_kmer_length
);

   import kwe_pkg::*;

   localparam int PTR_W = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
   localparam int K_W   = $clog2(MAX_KMER + 1);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_KMER - 1);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(MAX_KMER);
   localparam logic [K_W-1:0]   K_MAX    = K_W'(MAX_KMER);

   // Registers
   kwe_state_type    state_ff, state_in;
   logic [5:0]       kmer_length_ff;
   logic             past_header_ff;
   logic [K_W-1:0]   fill_ff, fill_in;
   logic [K_W-1:0]   since_n_ff, since_n_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [K_W-1:0]   remain_ff, remain_in;
   logic [7:0]       mem_q_ff;
   logic [7:0]       window_mem_ff [MAX_KMER];

   logic             in_fire;
   logic             out_fire;
   logic             store_byte;
   logic             emit;
   logic [K_W-1:0]   k_eff;
   logic [K_W-1:0]   fill_inc;
   logic [PTR_W:0]   start_sum;
   logic [PTR_W-1:0] start_ptr;
   logic [PTR_W-1:0] rd_addr;

   assign in_fire    = req_valid && !req_stall;
   assign out_fire   = rsp_valid && !rsp_stall;
   assign store_byte = in_fire && past_header_ff && (req_stream_byte != BYTE_NL);

   // Saturate k at the window depth
   always_comb begin
      if (int'(kmer_length_ff) > MAX_KMER) begin
         k_eff = K_MAX;
      end else begin
         k_eff = K_W'(kmer_length_ff);
      end
   end

   // Intake: fill count, run of non-N bytes, write pointer
   always_comb begin
      fill_inc = fill_ff + K_W'(1);
      if (req_stream_byte == BYTE_N) begin
         since_n_in = '0;
      end else if (since_n_ff == K_MAX) begin
         since_n_in = since_n_ff;
      end else begin
         since_n_in = since_n_ff + K_W'(1);
      end
      if (wr_ptr_ff == PTR_LAST) begin
         wr_ptr_in = '0;
      end else begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      // the newest fill_inc bytes are clean when the non-N run covers them
      emit = (k_eff != '0) && (fill_inc == k_eff) && (since_n_in >= k_eff);
      priority if (k_eff == '0) begin
         fill_in = (fill_ff == K_MAX) ? fill_ff : fill_inc;
      end else if (fill_inc == k_eff) begin
         fill_in = k_eff - K_W'(1);
      end else begin
         fill_in = fill_inc;
      end
      // oldest byte of the window sits k entries behind the new write pointer
      start_sum = {1'b0, wr_ptr_in} + DEPTH_X - (PTR_W + 1)'(k_eff);
      if (start_sum >= DEPTH_X) begin
         start_ptr = PTR_W'(start_sum - DEPTH_X);
      end else begin
         start_ptr = start_sum[PTR_W-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (store_byte && emit) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_fire && (remain_ff == K_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and read pointer control
   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      rsp_valid = 1'b0;
      rd_ptr_in = rd_ptr_ff;
      remain_in = remain_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (store_byte && emit) begin
               rd_ptr_in = start_ptr;
               remain_in = k_eff;
            end
         end
         ST_LOAD: begin
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (out_fire) begin
               remain_in = remain_ff - K_W'(1);
               rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Advance the read address with the pointer so the next byte is ready
   assign rd_addr       = (state_ff == ST_SEND) ? rd_ptr_in : rd_ptr_ff;
   assign rsp_kmer_char = mem_q_ff;
   assign rsp_kmer_last = (remain_ff == K_W'(1));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         kmer_length_ff <= KMER_LEN_RESET;
         past_header_ff <= 1'b0;
         fill_ff        <= '0;
         since_n_ff     <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         remain_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         remain_ff <= remain_in;
         if (in_fire && (req_stream_byte == BYTE_NL)) begin
            past_header_ff <= 1'b1;
         end
         // config write empties the window
         if (csr_valid && csr_ready) begin
            kmer_length_ff <= csr_kmer_length;
            fill_ff        <= '0;
         end else if (store_byte) begin
            fill_ff <= fill_in;
         end
         if (store_byte) begin
            since_n_ff <= since_n_in;
            wr_ptr_ff  <= wr_ptr_in;
         end
      end
   end

   // Window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_byte) begin
         window_mem_ff[wr_ptr_ff] <= req_stream_byte;
      end
      mem_q_ff <= window_mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> verif/kmer_window_checker.sv
// Checker for the k-mer window extractor: watches the byte, k-mer and csr channels,
// predicts every k-mer byte and compares it field by field. Depends on kwe_pkg.
`timescale 1ns / 1ps

module kmer_window_checker #(
   parameter int MAX_KMER = kwe_pkg::MAX_KMER_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_stream_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_kmer_char,
   input  logic       rsp_kmer_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [5:0] csr_kmer_length,
   output int         pending_count,
   output int         error_count
);
   import kwe_pkg::*;

   typedef struct packed {
      logic [7:0] kmer_char;
      logic       kmer_last;
   } kmer_beat_type;

   logic [7:0]    window_q[$];
   int            n_count;
   bit            seen_newline;
   logic [5:0]    kmer_len;
   kmer_beat_type kmer_beats_due[$];

   // Drop the oldest window byte and keep the 'N' count in step
   function automatic void drop_oldest_byte();
      if (window_q.size() != 0) begin
         if (window_q[0] == BYTE_N && n_count > 0)
            n_count--;
         window_q.delete(0);
      end
   endfunction

   // Shift one stream byte into the window and queue the k-mer it completes
   function automatic void shift_in_byte(input logic [7:0] stream_byte);
      int            k;
      kmer_beat_type beat;
      k = (kmer_len > MAX_KMER) ? MAX_KMER : int'(kmer_len);
      if (stream_byte == BYTE_NL) begin
         seen_newline = 1'b1;
      end else if (seen_newline) begin
         // with k = 0 the window never completes, so it just slides at full depth
         if (window_q.size() >= MAX_KMER)
            drop_oldest_byte();
         window_q.insert(window_q.size(), stream_byte);
         if (stream_byte == BYTE_N)
            n_count++;
         if (k != 0 && window_q.size() == k) begin
            if (n_count == 0) begin
               for (int i = 0; i < k; i++) begin
                  beat.kmer_char = window_q[i];
                  beat.kmer_last = (i == k - 1);
                  kmer_beats_due.insert(kmer_beats_due.size(), beat);
               end
            end
            drop_oldest_byte();
         end
      end
   endfunction

   // Track every transaction at the rising edge
   always @(posedge clock) begin
      kmer_beat_type due;
      if (reset) begin
         window_q.delete();
         kmer_beats_due.delete();
         n_count       = 0;
         seen_newline  = 1'b0;
         kmer_len      = KMER_LEN_RESET;
         pending_count = 0;
         error_count   = 0;
      end else begin
         // a length write empties the window but keeps the header state
         if (csr_valid && csr_ready) begin
            kmer_len = csr_kmer_length;
            window_q.delete();
            n_count = 0;
         end
         if (req_valid && !req_stall)
            shift_in_byte(req_stream_byte);
         // compare each k-mer byte with the oldest one due
         if (rsp_valid && !rsp_stall) begin
            if (kmer_beats_due.size() == 0) begin
               $error("unexpected k-mer byte: kmer_char %h kmer_last %b",
                      rsp_kmer_char, rsp_kmer_last);
               error_count++;
            end else begin
               due = kmer_beats_due[0];
               kmer_beats_due.delete(0);
               if (rsp_kmer_char !== due.kmer_char) begin
                  $error("kmer_char: expected %h, actual %h", due.kmer_char, rsp_kmer_char);
                  error_count++;
               end
               if (rsp_kmer_last !== due.kmer_last) begin
                  $error("kmer_last: expected %b, actual %b", due.kmer_last, rsp_kmer_last);
                  error_count++;
               end
            end
         end
         pending_count = kmer_beats_due.size();
      end
   end

endmodule

>>> verif/testbench.sv
// Top of the k-mer window extractor testbench: clock, reset, byte and length stimulus,
// output stalls and the verdict. Depends on kwe_pkg, the extractor and kmer_window_checker.
`timescale 1ns / 1ps

module testbench;
   import kwe_pkg::*;

   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_GT       = 8'h3E;
   localparam int         SETTLE_CYCLES = 40;
   localparam int         LONG_HOLD     = 400;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_stream_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_kmer_char;
   logic       rsp_kmer_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [5:0] csr_kmer_length;
   int         pending_count;
   int         error_count;
   bit         send_burst;

   kmer_window_extractor_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kmer_char   (rsp_kmer_char),
      .rsp_kmer_last   (rsp_kmer_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_kmer_length (csr_kmer_length)
   );

   kmer_window_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kmer_char   (rsp_kmer_char),
      .rsp_kmer_last   (rsp_kmer_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_kmer_length (csr_kmer_length),
      .pending_count   (pending_count),
      .error_count     (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run
   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

   // Draw a random idle gap, with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 15) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 17);
   endfunction

   // Mostly bases, some soft-masked, rare 'N', line breaks and arbitrary bytes
   function automatic logic [7:0] random_stream_byte();
      string upper_bases = "ACGT";
      string lower_bases = "acgtn";
      int    pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return upper_bases[$urandom_range(0, 3)];
      else if (pick < 72)
         return lower_bases[$urandom_range(0, 4)];
      else if (pick < 74)
         return BYTE_N;
      else if (pick < 77)
         return BYTE_NL;
      else if (pick < 80)
         return BYTE_CR;
      else if (pick < 82)
         return BYTE_GT;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one byte and hold it until the block takes the transaction
   task automatic send_byte(input logic [7:0] stream_byte);
      int gap;
      gap = draw_gap(send_burst);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_stream_byte <= stream_byte;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i]);
   endtask

   // Drain the block, then write a new k
   task automatic write_kmer_length(input logic [5:0] length);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_kmer_length <= length;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Output side: random stalls, two long hold-offs to back the block up
   initial begin : kmer_receiver
      int gap;
      int taken;
      bit burst;
      rsp_stall = 1'b0;
      taken     = 0;
      burst     = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         gap = draw_gap(burst);
         if (taken == 40 || taken == 700)
            gap = LONG_HOLD;
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Byte stream and length phases
   initial begin
      logic [5:0] phase_len[7];
      int         phase_items[7];
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_stream_byte = 8'h00;
      csr_valid       = 1'b0;
      csr_kmer_length = 6'd0;
      send_burst      = 1'b0;
      phase_len       = '{6'd32, 6'd63, 6'd0, 6'd2, 6'd31, 6'd0, 6'd18};
      phase_items     = '{45, 35, 20, 25, 35, 30, 30};
      phase_len[5]    = 6'($urandom_range(3, 16));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Header with an 'N' and 0xFF, dropped up to the first newline
      send_byte(BYTE_GT);
      send_byte(BYTE_N);
      send_byte(8'hFF);
      send_byte(BYTE_NL);
      // Reset k of 18: soft-masked bases, CR, zero byte, window across a line break
      send_text("ACGTacgtn");
      send_byte(8'h00);
      send_byte(BYTE_CR);
      send_byte(BYTE_NL);
      send_text("GATTACA");
      send_byte(8'hFF);
      // An uppercase 'N' blocks the next windows
      send_byte(BYTE_N);

      // Shortest k: 'N' alone is blocked, the byte extremes pass
      write_kmer_length(6'd1);
      send_byte(BYTE_N);
      send_byte(8'h00);
      send_byte(8'hFF);
      repeat (15) send_byte(random_stream_byte());

      // Longest, saturating, zero and assorted lengths
      foreach (phase_len[p]) begin
         write_kmer_length(phase_len[p]);
         repeat (phase_items[p]) send_byte(random_stream_byte());
      end

      // Drain and let the block settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
